>>> hdl/p384_modular_arith_unit_macros.svh
// assertion macros for the p384 modular arithmetic unit
`ifndef P384_MODULAR_ARITH_UNIT_MACROS_SVH
`define P384_MODULAR_ARITH_UNIT_MACROS_SVH

// property that must hold whenever reset is low
`define P384_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// signal never unknown once out of reset
`define P384_ASSERT_KNOWN(label, sig, msg) \
   `P384_ASSERT(label, !$isunknown(sig), msg)

`endif

>>> hdl/p384_pkg.sv
// shared types and constants for the p384 modular arithmetic unit
`timescale 1ns / 1ps
package p384_pkg;

   localparam int LIMBS_DEFAULT = 6;
   localparam int LIMB_W = 64;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_MULP  = 2'd1,
      CMD_MULN  = 2'd2,
      CMD_ZERO  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_TOP,
      ST_CMP,
      ST_SUB,
      ST_OUT
   } state_type;

   // modulus limb for a given operation and limb index
   function automatic logic [LIMB_W-1:0] mod_limb(input logic is_n, input logic [2:0] i);
      logic [LIMB_W-1:0] v;
      v = 64'hffffffffffffffff;
      if (is_n) begin
         case (i)
            3'd0: v = 64'hecec196accc52973;
            3'd1: v = 64'h581a0db248b0a77a;
            3'd2: v = 64'hc7634d81f4372ddf;
            default: v = 64'hffffffffffffffff;
         endcase
      end else begin
         case (i)
            3'd0: v = 64'h00000000ffffffff;
            3'd1: v = 64'hffffffff00000000;
            3'd2: v = 64'hfffffffffffffffe;
            default: v = 64'hffffffffffffffff;
         endcase
      end
      return v;
   endfunction

   function automatic logic [LIMB_W-1:0] minv(input logic is_n);
      return is_n ? 64'h6ed46089e88fdc45 : 64'h0000000100000001;
   endfunction

endpackage

>>> hdl/p384_front.sv
// front end: collects limbs, issues a job with the command into the queue
`timescale 1ns / 1ps
module p384_front #(
   parameter int LIMBS = p384_pkg::LIMBS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_cmd,
   input  logic [63:0]              req_a_limb,
   input  logic [63:0]              req_b_limb,
   output logic                     job_valid,
   input  logic                     job_ready,
   output p384_pkg::cmd_type        job_cmd,
   output logic [LIMBS-1:0][63:0]   job_a,
   output logic [LIMBS-1:0][63:0]   job_b
);
   localparam int CW = $clog2(LIMBS + 1);
   logic [CW-1:0]            count_ff, count_in;
   logic [LIMBS-1:0][63:0]   a_ff, b_ff;
   logic                     full_ff, full_in;
   p384_pkg::cmd_type        cmd_ff;
   logic                     take;

   // single-entry queue: operands held until the back end takes them
   assign req_ready = !full_ff;
   assign take = req_valid && req_ready;
   assign job_valid = full_ff;
   assign job_cmd = cmd_ff;
   assign job_a = a_ff;
   assign job_b = b_ff;

   always_comb begin
      count_in = count_ff;
      full_in = full_ff;
      if (job_valid && job_ready) full_in = 1'b0;
      if (take) begin
         if (count_ff == CW'(LIMBS - 1)) begin
            count_in = '0;
            full_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         full_ff <= full_in;
      end
      if (take) begin
         a_ff[count_ff[$clog2(LIMBS)-1:0]] <= req_a_limb;
         b_ff[count_ff[$clog2(LIMBS)-1:0]] <= req_b_limb;
         cmd_ff <= p384_pkg::cmd_type'(req_cmd);
      end
   end
endmodule

>>> hdl/p384_back.sv
// back end: word-serial montgomery multiply with one 32x32 multiplier, modular add and zero result
`timescale 1ns / 1ps
`include "p384_modular_arith_unit_macros.svh"
module p384_back #(
   parameter int LIMBS = p384_pkg::LIMBS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   output logic                     job_ready,
   input  p384_pkg::cmd_type        job_cmd,
   input  logic [LIMBS-1:0][63:0]   job_a,
   input  logic [LIMBS-1:0][63:0]   job_b,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [63:0]              rsp_r_limb,
   output logic                     rsp_last
);
   localparam int IW = $clog2(LIMBS + 1);
   localparam int AW = $clog2(LIMBS);
   p384_pkg::state_type  state_ff, state_in;
   p384_pkg::cmd_type    cmd_ff;
   logic [LIMBS-1:0][63:0] a_ff, b_ff;
   logic [LIMBS+1:0][63:0] t_ff;
   logic [IW-1:0]        i_ff, i_in, j_ff, j_in;
   logic [1:0]           k_ff, k_in;
   logic [63:0]          c_ff, q_ff;
   logic                 ge_ff, bor_ff, is_n, is_mul;
   logic [127:0]         pacc_ff, acc;
   logic [63:0]          mx, my, madd, cadd;
   logic [31:0]          px, py;
   logic [63:0]          pp;
   logic [64:0]          sum65;
   logic [64:0]          dif65;
   logic [64:0]          add65;
   logic [63:0]          mlimb;
   logic                 take_job, mul_step, step_done;

   function automatic logic sum65_red(input logic [63:0] x, input logic [63:0] y);
      logic [64:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[64];
   endfunction

   assign is_n = (cmd_ff == p384_pkg::CMD_MULN);
   assign is_mul = (cmd_ff == p384_pkg::CMD_MULP) || (cmd_ff == p384_pkg::CMD_MULN);
   assign job_ready = (state_ff == p384_pkg::ST_IDLE);
   assign take_job = job_valid && job_ready;
   assign mlimb = p384_pkg::mod_limb(is_n, j_ff[2:0]);
   // each 64x64 product is built from four 32x32 partial products, one a cycle
   assign mul_step = (state_ff == p384_pkg::ST_MUL && is_mul)
                  || state_ff == p384_pkg::ST_TOP || state_ff == p384_pkg::ST_RED;
   assign step_done = (k_ff == 2'd3);

   // multiply operands per phase
   always_comb begin
      mx = '0; my = '0; madd = '0; cadd = '0;
      if (state_ff == p384_pkg::ST_MUL) begin
         mx = a_ff[j_ff[AW-1:0]];
         my = b_ff[i_ff[AW-1:0]];
         madd = t_ff[j_ff];
         cadd = c_ff;
      end else if (state_ff == p384_pkg::ST_TOP) begin
         // quotient word: low 64 bits of t0 times the negated modulus inverse
         mx = t_ff[0];
         my = p384_pkg::minv(is_n);
      end else begin
         mx = q_ff;
         my = mlimb;
         madd = t_ff[j_ff];
         cadd = c_ff;
      end
      px = k_ff[1] ? mx[63:32] : mx[31:0];
      py = k_ff[0] ? my[63:32] : my[31:0];
      pp = 64'(px) * 64'(py);
      if (k_ff == 2'd0) acc = {64'd0, madd} + {64'd0, cadd} + {64'd0, pp};
      else if (k_ff == 2'd3) acc = pacc_ff + {pp, 64'd0};
      else acc = pacc_ff + {32'd0, pp, 32'd0};
      sum65 = {1'b0, t_ff[LIMBS]} + {1'b0, c_ff};
      dif65 = {1'b0, t_ff[j_ff]} - {1'b0, mlimb} - {64'd0, bor_ff};
      add65 = {1'b0, a_ff[j_ff[AW-1:0]]} + {1'b0, b_ff[j_ff[AW-1:0]]} + {64'd0, c_ff[0]};
   end

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = mul_step ? k_ff + 2'd1 : 2'd0;
      unique case (state_ff)
         p384_pkg::ST_IDLE: if (job_valid) state_in = p384_pkg::ST_MUL;
         p384_pkg::ST_MUL:
            if (!is_mul) begin
               // add: one limb per cycle, then compare; zero goes straight to output
               if (j_ff == IW'(LIMBS - 1)) begin
                  j_in = IW'(LIMBS - 1);
                  state_in = (cmd_ff == p384_pkg::CMD_ZERO) ? p384_pkg::ST_OUT
                                                            : p384_pkg::ST_CMP;
                  if (cmd_ff == p384_pkg::CMD_ZERO) j_in = '0;
               end else j_in = j_ff + 1'b1;
            end else if (step_done) begin
               if (j_ff == IW'(LIMBS - 1)) begin
                  j_in = '0;
                  state_in = p384_pkg::ST_TOP;
               end else j_in = j_ff + 1'b1;
            end
         p384_pkg::ST_TOP: if (step_done) state_in = p384_pkg::ST_RED;
         p384_pkg::ST_RED:
            if (step_done) begin
               if (j_ff == IW'(LIMBS - 1)) begin
                  j_in = '0;
                  if (i_ff == IW'(LIMBS - 1)) begin
                     j_in = IW'(LIMBS - 1);
                     state_in = p384_pkg::ST_CMP;
                  end else begin
                     i_in = i_ff + 1'b1;
                     state_in = p384_pkg::ST_MUL;
                  end
               end else j_in = j_ff + 1'b1;
            end
         p384_pkg::ST_CMP:
            // top-down compare of t against the modulus, one limb a cycle
            if (ge_ff || t_ff[j_ff] != mlimb || j_ff == '0) begin
               j_in = '0;
               state_in = (ge_ff || t_ff[j_ff] >= mlimb) ? p384_pkg::ST_SUB
                                                         : p384_pkg::ST_OUT;
            end else j_in = j_ff - 1'b1;
         p384_pkg::ST_SUB:
            if (j_ff == IW'(LIMBS - 1)) begin
               j_in = '0;
               state_in = p384_pkg::ST_OUT;
            end else j_in = j_ff + 1'b1;
         p384_pkg::ST_OUT:
            if (rsp_ready) begin
               if (j_ff == IW'(LIMBS - 1)) state_in = p384_pkg::ST_IDLE;
               else j_in = j_ff + 1'b1;
            end
         default: state_in = p384_pkg::ST_IDLE;
      endcase
      if (take_job) begin
         i_in = '0;
         j_in = '0;
      end
   end

   assign rsp_valid = (state_ff == p384_pkg::ST_OUT);
   assign rsp_r_limb = t_ff[j_ff];
   assign rsp_last = (j_ff == IW'(LIMBS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= p384_pkg::ST_IDLE;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
      end
      pacc_ff <= acc;
      unique case (state_ff)
         p384_pkg::ST_IDLE: begin
            a_ff <= job_a;
            b_ff <= job_b;
            cmd_ff <= job_cmd;
            t_ff <= '0;
            c_ff <= '0;
            ge_ff <= 1'b0;
            bor_ff <= 1'b0;
         end
         p384_pkg::ST_MUL:
            if (cmd_ff == p384_pkg::CMD_ADD) begin
               t_ff[j_ff] <= add65[63:0];
               if (j_ff == IW'(LIMBS - 1)) begin
                  ge_ff <= add65[64];
                  c_ff <= '0;
               end else c_ff <= {63'd0, add65[64]};
            end else if (cmd_ff == p384_pkg::CMD_ZERO) begin
               t_ff[j_ff] <= '0;
            end else if (step_done) begin
               t_ff[j_ff] <= acc[63:0];
               c_ff <= acc[127:64];
            end
         p384_pkg::ST_TOP:
            if (step_done) begin
               t_ff[LIMBS] <= sum65[63:0];
               t_ff[LIMBS+1] <= {63'd0, sum65[64]};
               q_ff <= acc[63:0];
               c_ff <= '0;
            end
         p384_pkg::ST_RED:
            if (step_done) begin
               if (j_ff != '0) t_ff[j_ff - 1'b1] <= acc[63:0];
               if (j_ff == IW'(LIMBS - 1)) begin
                  t_ff[LIMBS-1] <= t_ff[LIMBS] + acc[127:64];
                  t_ff[LIMBS] <= t_ff[LIMBS+1]
                     + {63'd0, sum65_red(t_ff[LIMBS], acc[127:64])};
                  t_ff[LIMBS+1] <= '0;
                  c_ff <= '0;
                  // only the last outer step's value is used by the compare
                  ge_ff <= (t_ff[LIMBS+1]
                     + {63'd0, sum65_red(t_ff[LIMBS], acc[127:64])}) != '0;
               end else c_ff <= acc[127:64];
            end
         p384_pkg::ST_CMP: bor_ff <= 1'b0;
         p384_pkg::ST_SUB: begin
            t_ff[j_ff] <= dif65[63:0];
            bor_ff <= dif65[64];
         end
         p384_pkg::ST_OUT: ;
         default: ;
      endcase
   end

   `P384_ASSERT(a_out_idle, rsp_valid |-> !job_ready, "result shown while taking a job")
   `P384_ASSERT(a_last_hold, (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_r_limb), "stalled result changed")
   `P384_ASSERT(a_done, (rsp_valid && rsp_ready && rsp_last) |=> job_ready, "no return to idle after last limb")
   `P384_ASSERT_KNOWN(a_valid_known, rsp_valid, "rsp_valid unknown")
endmodule

>>> hdl/p384_modular_arith_unit.sv
// top level of the p384 modular arithmetic unit
`timescale 1ns / 1ps
// Six requests load the 384-bit operands a and b one 64-bit limb each, lowest first; the cmd
// of the sixth request picks add mod p, montgomery multiply mod p or mod n, or a zero result.
// Six rsp limbs follow, lowest first, with rsp_last on the sixth. A montgomery multiply is
// paced by the one shared 32x32 multiplier (78 limb products including the six quotient
// words, each built from four partial products), then a final compare/subtract and the
// output limbs. The next six limbs may load while a job is being worked on.
module p384_modular_arith_unit #(
   parameter int LIMBS = p384_pkg::LIMBS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_a_limb,
   input  logic [63:0] req_b_limb,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_r_limb,
   output logic        rsp_last
);
   logic                   job_valid, job_ready;
   p384_pkg::cmd_type      job_cmd;
   logic [LIMBS-1:0][63:0] job_a, job_b;

   p384_front #(.LIMBS(LIMBS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_a_limb, .req_b_limb,
      .job_valid, .job_ready, .job_cmd, .job_a, .job_b
   );

   p384_back #(.LIMBS(LIMBS)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job_cmd, .job_a, .job_b,
      .rsp_valid, .rsp_ready, .rsp_r_limb, .rsp_last
   );
endmodule
